// ===== hw/rtl/atct_pkg.sv =====
// ----------------------------------------------------------------------------
// atct_pkg: shared types and constants of the aging tag cache table
// Table geometry, field widths, opcodes and the request/response structs.
// ----------------------------------------------------------------------------
`default_nettype none

package atct_pkg;

	// table size and derived widths
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int KEY_W   = 32;
	localparam int GEO_W   = 32;
	localparam int AGE_W   = 8;
	localparam int SLOT_W  = 4;
	localparam int EVICT_W = 5;

	localparam logic [AGE_W-1:0] LIFE_PERIOD_RST = AGE_W'(10);

	// opcodes
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_CHECK  = 3'd0;
	localparam op_t OP_REMOVE = 3'd1;
	localparam op_t OP_CLEAR  = 3'd2;
	localparam op_t OP_TICK   = 3'd3;
	localparam op_t OP_RESET  = 3'd4;

	typedef struct packed {
		op_t                     opcode;
		logic [KEY_W-1:0]        key;
		logic signed [GEO_W-1:0] pos_x;
		logic signed [GEO_W-1:0] pos_y;
		logic signed [GEO_W-1:0] size_w;
		logic signed [GEO_W-1:0] size_h;
	} req_t;

	typedef struct packed {
		logic               found;
		logic               same_geometry;
		logic [SLOT_W-1:0]  slot;
		logic               full_res;
		logic [EVICT_W-1:0] evicted_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/atct_if.sv =====
// ----------------------------------------------------------------------------
// atct_if: channel interfaces of the aging tag cache table
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface atct_req_if
	import atct_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         opcode;
	logic [KEY_W-1:0]        key;
	logic signed [GEO_W-1:0] pos_x;
	logic signed [GEO_W-1:0] pos_y;
	logic signed [GEO_W-1:0] size_w;
	logic signed [GEO_W-1:0] size_h;

	modport source (output valid, opcode, key, pos_x, pos_y, size_w, size_h, input ready);
	modport sink   (input valid, opcode, key, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface atct_rsp_if
	import atct_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               found;
	logic               same_geometry;
	logic [SLOT_W-1:0]  slot;
	logic               full_res;
	logic [EVICT_W-1:0] evicted_count;

	modport source (output valid, found, same_geometry, slot, full_res, evicted_count,
		input ready);
	modport sink   (input valid, found, same_geometry, slot, full_res, evicted_count,
		output ready);
endinterface

interface atct_cfg_if
	import atct_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [AGE_W-1:0] life_period;

	modport source (output valid, life_period, input ready);
	modport sink   (input valid, life_period, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/atct_table.sv =====
// ----------------------------------------------------------------------------
// atct_table: entry storage and operation logic
// Holds all slots, compares every key in parallel, ages entries on tick and
// forms the response of the request that executes in this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module atct_table
	import atct_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             exec,
	input  wire req_t             req,
	input  wire logic [AGE_W-1:0] life_period,
	output rsp_t                  rsp
);

	// slot storage: valid bits reset, payload undefined until written
	logic [ENTRIES-1:0]      valid_q;
	logic [KEY_W-1:0]        key_q    [ENTRIES];
	logic [GEO_W-1:0]        pos_x_q  [ENTRIES];
	logic [GEO_W-1:0]        pos_y_q  [ENTRIES];
	logic [GEO_W-1:0]        size_w_q [ENTRIES];
	logic [GEO_W-1:0]        size_h_q [ENTRIES];
	logic [AGE_W-1:0]        age_q    [ENTRIES];

	logic [ENTRIES-1:0]      match;
	logic [ENTRIES-1:0]      hit_oh;
	logic [ENTRIES-1:0]      free_oh;
	logic [ENTRIES-1:0]      expire;
	logic [ENTRIES-1:0]      geo_eq;
	logic [AGE_W:0]          age_inc  [ENTRIES];
	logic                    hit;
	logic                    has_free;
	logic [IDX_W-1:0]        hit_idx;
	logic [IDX_W-1:0]        free_idx;
	logic [CNT_W-1:0]        valid_cnt;
	logic [CNT_W-1:0]        expire_cnt;

	logic [ENTRIES-1:0]      valid_nxt;
	logic [ENTRIES-1:0]      wr_key;
	logic [ENTRIES-1:0]      wr_geo;
	logic [ENTRIES-1:0]      age_clr;
	logic [ENTRIES-1:0]      age_upd;

	// parallel tag compare, aging and geometry compare
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]   = valid_q[i] && (key_q[i] == req.key);
			age_inc[i] = {1'b0, age_q[i]} + (AGE_W+1)'(1);
			expire[i]  = valid_q[i] && (age_inc[i] > {1'b0, life_period});
			geo_eq[i]  = (pos_x_q[i] == req.pos_x) && (pos_y_q[i] == req.pos_y) &&
				(size_w_q[i] == req.size_w) && (size_h_q[i] == req.size_h);
		end
	end

	// lowest matching slot and lowest free slot, one-hot
	assign hit_oh   = match & (~match + ENTRIES'(1));
	assign free_oh  = ~valid_q & (valid_q + ENTRIES'(1));
	assign hit      = |match;
	assign has_free = ~&valid_q;

	// one-hot to index
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_oh[i])  hit_idx  = hit_idx  | IDX_W'(i);
			if (free_oh[i]) free_idx = free_idx | IDX_W'(i);
		end
	end

	assign valid_cnt  = CNT_W'($countones(valid_q));
	assign expire_cnt = CNT_W'($countones(expire));

	// opcode decode: next valid bits, write enables and response
	always_comb begin
		valid_nxt = valid_q;
		wr_key    = '0;
		wr_geo    = '0;
		age_clr   = '0;
		age_upd   = '0;
		rsp       = '0;
		unique case (req.opcode)
			OP_CHECK: begin
				if (hit) begin
					age_clr            = hit_oh;
					rsp.found          = 1'b1;
					rsp.same_geometry  = |(hit_oh & geo_eq);
					rsp.slot           = SLOT_W'(hit_idx);
				end else if (has_free) begin
					valid_nxt = valid_q | free_oh;
					wr_key    = free_oh;
					wr_geo    = free_oh;
					age_clr   = free_oh;
					rsp.slot  = SLOT_W'(free_idx);
				end else begin
					rsp.full_res = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					valid_nxt = valid_q & ~hit_oh;
					rsp.found = 1'b1;
					rsp.slot  = SLOT_W'(hit_idx);
				end
			end
			OP_CLEAR: begin
				valid_nxt         = '0;
				rsp.evicted_count = EVICT_W'(valid_cnt);
			end
			OP_TICK: begin
				valid_nxt         = valid_q & ~expire;
				age_upd           = valid_q & ~expire;
				rsp.evicted_count = EVICT_W'(expire_cnt);
			end
			OP_RESET: begin
				if (hit) begin
					wr_geo    = hit_oh;
					age_clr   = hit_oh;
					rsp.found = 1'b1;
					rsp.slot  = SLOT_W'(hit_idx);
				end
			end
			default: begin
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (exec) begin
			valid_q <= valid_nxt;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (exec) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_key[i]) begin
					key_q[i] <= req.key;
				end
				if (wr_geo[i]) begin
					pos_x_q[i]  <= req.pos_x;
					pos_y_q[i]  <= req.pos_y;
					size_w_q[i] <= req.size_w;
					size_h_q[i] <= req.size_h;
				end
				if (age_clr[i]) begin
					age_q[i] <= '0;
				end else if (age_upd[i]) begin
					age_q[i] <= age_inc[i][AGE_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/aging_tag_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// aging_tag_cache_table_unit: fully associative tag table with age eviction
// Top level: input register, table execution stage, response register.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per transfer (opcode, key, position, size).
//   rsp  : one response per request, in request order.
//   cfg  : writes life_period; always ready. Write only while the unit is idle.
// Timing:
//   A request transfer lands in the input register; the table executes it and
//   the response register loads, raising rsp.valid, once the response register
//   is free or draining. One request per cycle is sustained while rsp is not
//   stalled: every operation reads and updates all slots in the execution stage.
// Reset:
//   arst_n clears all slot valid bits, the pipeline valids and sets
//   life_period to 10. Slot contents need no clearing.
// Back-pressure:
//   When rsp is stalled the finished response holds in the response register,
//   one more request waits in the input register, and req.ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_tag_cache_table_unit
	import atct_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	atct_cfg_if.sink    cfg,
	atct_req_if.sink    req,
	atct_rsp_if.source  rsp
);

	logic             valid_s1;
	req_t             req_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [AGE_W-1:0] life_period_q;
	rsp_t             tbl_rsp;
	logic             exec;

	// stage 1 executes when the response register is free or draining
	assign exec      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || exec;
	assign cfg.ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_period_q <= LIFE_PERIOD_RST;
		end else if (cfg.valid) begin
			life_period_q <= cfg.life_period;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{opcode: req.opcode, key: req.key, pos_x: req.pos_x,
				pos_y: req.pos_y, size_w: req.size_w, size_h: req.size_h};
		end
	end

	atct_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.exec        (exec),
		.req         (req_s1),
		.life_period (life_period_q),
		.rsp         (tbl_rsp)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= tbl_rsp;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = rsp_q.found;
	assign rsp.same_geometry = rsp_q.same_geometry;
	assign rsp.slot          = rsp_q.slot;
	assign rsp.full_res      = rsp_q.full_res;
	assign rsp.evicted_count = rsp_q.evicted_count;

endmodule

`default_nettype wire
